>>> rtl/ils_pkg.sv
package ils_pkg;

  localparam int ValW = 32;
  localparam int OpW  = 3;
  localparam int StW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_READ      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_INS_AT    = 3'd3,
    OP_DELETE    = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } cell_cmd_t;

endpackage

>>> rtl/ils_cell.sv
module ils_cell #(
  parameter int Idx  = 0,
  parameter int PosW = 5
) (
  input  logic                             clk_i,
  input  ils_pkg::cell_cmd_t               cmd_i,
  input  logic [PosW-1:0]                  at_i,
  input  logic signed [ils_pkg::ValW-1:0]  item_i,
  input  logic signed [ils_pkg::ValW-1:0]  left_i,
  input  logic signed [ils_pkg::ValW-1:0]  right_i,
  output logic signed [ils_pkg::ValW-1:0]  data_o,
  output logic signed [ils_pkg::ValW-1:0]  hit_o
);
  import ils_pkg::*;

  localparam logic [PosW-1:0] MyIdx = PosW'(Idx);

  logic signed [ValW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    priority if (cmd_i.ins && (at_i < MyIdx)) begin
      data_d = left_i;
    end else if (cmd_i.ins && (at_i == MyIdx)) begin
      data_d = item_i;
    end else if (cmd_i.del && (at_i <= MyIdx)) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = (cmd_i.rd && (at_i == MyIdx)) ? data_q : '0;

endmodule

>>> rtl/indexed_list_store.sv
// Channel | Direction | Handshake              | Fields
// in      | in        | in_valid_i, in_stall_o   | operation_i, position_i, item_value_i
// out     | out       | out_valid_o, out_stall_i | read_value_o, status_o, count_now_o
//
// One transaction per cycle while the input is not stalled: every cell decides
// locally to hold, shift up or shift down; the result is registered on acceptance.
// A read selects one cell through an OR tree across all CAPACITY cells.
// Reset clears the count and the output valid; cell contents stay undefined.
// The input stalls only while a result waits and the output is stalled.
module indexed_list_store #(
  parameter  int CAPACITY = 16,
  localparam int PosW     = $clog2(CAPACITY + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ils_pkg::OpW-1:0]          operation_i,
  input  logic [PosW-1:0]                  position_i,
  input  logic signed [ils_pkg::ValW-1:0]  item_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [ils_pkg::ValW-1:0]  read_value_o,
  output logic [ils_pkg::StW-1:0]          status_o,
  output logic [PosW-1:0]                  count_now_o
);
  import ils_pkg::*;

  localparam logic [PosW-1:0] Cap = PosW'(CAPACITY);

  logic                   in_acc;
  logic                   out_valid_q, out_valid_d;
  logic [PosW-1:0]        count_q, count_d;
  logic signed [ValW-1:0] read_value_q;
  status_e                status_q, status_d;
  logic [PosW-1:0]        count_now_q;

  op_e                    op;
  logic                   full;
  logic                   ins, del, rd_en;
  logic [PosW-1:0]        at;
  cell_cmd_t              cmd;
  logic signed [ValW-1:0] rd_value;

  logic signed [ValW-1:0] cell_val [CAPACITY];
  logic signed [ValW-1:0] cell_hit [CAPACITY];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign op         = op_e'(operation_i);
  assign full       = (count_q == Cap);

  always_comb begin
    ins      = 1'b0;
    del      = 1'b0;
    rd_en    = 1'b0;
    at       = position_i;
    status_d = ST_OK;
    unique case (op)
      OP_READ: begin
        if (position_i < count_q) rd_en = 1'b1;
        else status_d = ST_RANGE;
      end
      OP_INS_FRONT: begin
        at = '0;
        if (full) status_d = ST_FULL;
        else ins = 1'b1;
      end
      OP_INS_BACK: begin
        at = count_q;
        if (full) status_d = ST_FULL;
        else ins = 1'b1;
      end
      OP_INS_AT: begin
        priority if (position_i > count_q) status_d = ST_RANGE;
        else if (full) status_d = ST_FULL;
        else ins = 1'b1;
      end
      OP_DELETE: begin
        if (position_i < count_q) del = 1'b1;
        else status_d = ST_RANGE;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ins) count_d = count_q + PosW'(1);
    if (del) count_d = count_q - PosW'(1);
  end

  assign cmd.ins = ins & in_acc;
  assign cmd.del = del & in_acc;
  assign cmd.rd  = rd_en;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ValW-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = item_value_i;
    end else begin : g_mid
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_next
      assign right_v = cell_val[g+1];
    end
    ils_cell #(
      .Idx  (g),
      .PosW (PosW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .at_i    (at),
      .item_i  (item_value_i),
      .left_i  (left_v),
      .right_i (right_v),
      .data_o  (cell_val[g]),
      .hit_o   (cell_hit[g])
    );
  end

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | cell_hit[i];
    end
  end

  assign out_valid_d = in_acc | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      read_value_q <= rd_value;
      status_q     <= status_d;
      count_now_q  <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign count_now_o  = count_now_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cap)
    else $error("entry count beyond capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_FULL) |-> (count_now_q == Cap))
    else $error("full status reported below capacity");

  a_delete_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_DELETE && position_i < count_q)
      |=> (count_q == $past(count_q) - PosW'(1)))
    else $error("delete did not drop the count");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_INS_BACK && !full)
      |=> (count_q == $past(count_q) + PosW'(1) && count_now_q == count_q))
    else $error("append did not advance the count");

endmodule

>>> bench/indexed_list_store_tb.sv
`timescale 1ns / 100ps

module indexed_list_store_tb;
  import ils_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int PosW       = $clog2(CAPACITY + 1);
  localparam int RandomReqs = 1700;
  localparam int DrainEvery = 250;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] value;
    logic            wait_idle;
  } request_t;

  typedef struct packed {
    logic [ValW-1:0] read_value;
    status_e         status;
    logic [PosW-1:0] count_now;
  } reply_t;

  typedef struct packed {
    logic [CAPACITY-1:0][ValW-1:0] cells;
    logic [PosW-1:0]               count;
  } store_t;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_stall_o;
  logic [OpW-1:0]         operation_i  = '0;
  logic [PosW-1:0]        position_i   = '0;
  logic signed [ValW-1:0] item_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i  = 1'b0;
  logic signed [ValW-1:0] read_value_o;
  logic [StW-1:0]         status_o;
  logic [PosW-1:0]        count_now_o;

  request_t pending_requests[$];
  reply_t   awaited_replies[$];
  store_t   plan_store;
  store_t   shadow_store;

  logic in_taken = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   stall_mode = 0;
  int   stall_phase_left = 0;
  int   stall_tick = 0;

  int errors = 0;
  int replies_checked = 0;
  int range_refusals = 0;
  int full_refusals = 0;
  int peak_count = 0;

  indexed_list_store #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_now_o  (count_now_o)
  );

  function automatic void open_slot(inout store_t s, input int at, input logic [ValW-1:0] v);
    for (int i = CAPACITY - 1; i > 0; i--) begin
      if (i > at && i <= s.count) begin
        s.cells[i] = s.cells[i-1];
      end
    end
    s.cells[at] = v;
    s.count = s.count + 1'b1;
  endfunction

  function automatic reply_t apply_request(input request_t r, inout store_t s);
    reply_t rep;
    logic   full;
    rep.read_value = '0;
    rep.status = ST_OK;
    full = (s.count >= CAPACITY);
    case (r.op)
      OP_READ: begin
        if (r.pos < s.count) rep.read_value = s.cells[r.pos];
        else rep.status = ST_RANGE;
      end
      OP_INS_FRONT: begin
        if (full) rep.status = ST_FULL;
        else open_slot(s, 0, r.value);
      end
      OP_INS_BACK: begin
        if (full) rep.status = ST_FULL;
        else open_slot(s, s.count, r.value);
      end
      OP_INS_AT: begin
        if (r.pos > s.count) rep.status = ST_RANGE;
        else if (full) rep.status = ST_FULL;
        else open_slot(s, r.pos, r.value);
      end
      OP_DELETE: begin
        if (r.pos < s.count) begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (i >= r.pos && i + 1 < s.count) s.cells[i] = s.cells[i+1];
          end
          s.count = s.count - 1'b1;
        end else begin
          rep.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    rep.count_now = s.count;
    return rep;
  endfunction

  task automatic add_request(input logic [OpW-1:0] op, input int pos,
                             input logic [ValW-1:0] value, input logic wait_idle);
    request_t r;
    r.op = op;
    r.pos = pos[PosW-1:0];
    r.value = value;
    r.wait_idle = wait_idle;
    void'(apply_request(r, plan_store));
    pending_requests.push_back(r);
  endtask

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OpW-1:0] pick_op(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return OpW'($urandom_range(OP_DELETE + 1, (1 << OpW) - 1));
    roll = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (roll < 70) return OpW'($urandom_range(OP_INS_FRONT, OP_INS_AT));
        return (roll < 90) ? OP_READ : OP_DELETE;
      end
      1: begin
        if (roll < 60) return OP_DELETE;
        return (roll < 85) ? OP_READ : OpW'($urandom_range(OP_INS_FRONT, OP_INS_AT));
      end
      default: return OpW'($urandom_range(OP_READ, OP_DELETE));
    endcase
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("indexed_list_store: mismatch");
    $finish;
  end

  initial begin
    int made;
    int mode;
    int segment_left;
    logic [OpW-1:0] op;
    int pos;

    plan_store = '0;
    shadow_store = '0;

    add_request(OP_READ, 0, $urandom, 1'b0);
    add_request(OP_DELETE, 0, $urandom, 1'b0);
    add_request(OP_INS_AT, 1, $urandom, 1'b0);
    add_request(OP_INS_AT, 0, 32'h8000_0000, 1'b0);
    add_request(OP_INS_FRONT, 0, 32'h7fff_ffff, 1'b0);
    add_request(OP_INS_BACK, (1 << PosW) - 1, '1, 1'b0);
    for (int i = 0; i < CAPACITY - 3; i++) begin
      if (i % 2 == 0) add_request(OP_INS_FRONT, 0, $urandom, 1'b0);
      else add_request(OP_INS_AT, (3 + i) / 2, $urandom, 1'b0);
    end
    add_request(OP_INS_FRONT, 0, $urandom, 1'b0);
    add_request(OP_INS_BACK, 0, $urandom, 1'b0);
    add_request(OP_INS_AT, CAPACITY, $urandom, 1'b0);
    add_request(OP_INS_AT, CAPACITY + 1, $urandom, 1'b0);
    add_request(OP_READ, CAPACITY - 1, 0, 1'b0);
    add_request(OP_READ, CAPACITY, 0, 1'b0);
    add_request(OP_DELETE, CAPACITY - 1, 0, 1'b0);
    add_request(OP_DELETE, 0, 0, 1'b0);
    for (int c = OP_DELETE + 1; c < (1 << OpW); c++) begin
      add_request(OpW'(c), $urandom_range(0, (1 << PosW) - 1), $urandom, 1'b0);
    end

    made = 0;
    segment_left = 0;
    mode = 2;
    while (made < RandomReqs) begin
      if (segment_left == 0) begin
        mode = $urandom_range(0, 2);
        segment_left = $urandom_range(30, 90);
      end
      segment_left--;
      op = pick_op(mode);
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, (1 << PosW) - 1);
      else pos = $urandom_range(0, plan_store.count);
      add_request(op, pos, pick_value(), (made % DrainEvery) == 0);
      if (op <= OP_DELETE) made++;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || in_valid_i || awaited_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);

    $display("checked %0d replies: %0d out of range, %0d refused as full, peak count %0d",
             replies_checked, range_refusals, full_refusals, peak_count);
    if (errors == 0) begin
      $display("indexed_list_store: match");
    end else begin
      $display("indexed_list_store: mismatch");
    end
    $finish;
  end

  // driver: hold the payload until the transaction is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].wait_idle && awaited_replies.size() != 0)) begin
        operation_i <= pending_requests[0].op;
        position_i <= pending_requests[0].pos;
        item_value_i <= pending_requests[0].value;
        in_valid_i <= 1'b1;
        void'(pending_requests.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_phase_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase_left <= $urandom_range(20, 120);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= $urandom_range(0, 1);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_tick % 5) < 2;
    endcase
  end

  // monitor: record accepted requests, then check the reply stream
  always @(posedge clk_i) begin
    request_t r;
    reply_t   want;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      r.op = operation_i;
      r.pos = position_i;
      r.value = item_value_i;
      r.wait_idle = 1'b0;
      want = apply_request(r, shadow_store);
      awaited_replies.push_back(want);
      if (shadow_store.count > peak_count) peak_count = shadow_store.count;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected reply read_value %0d status %0d count %0d",
                 $time, read_value_o, status_o, count_now_o);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        replies_checked++;
        if (want.status == ST_RANGE) range_refusals++;
        if (want.status == ST_FULL) full_refusals++;
        if (read_value_o !== want.read_value) begin
          $display("%0t: read_value expected %0d actual %0d",
                   $time, $signed(want.read_value), read_value_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
        if (count_now_o !== want.count_now) begin
          $display("%0t: count_now expected %0d actual %0d",
                   $time, want.count_now, count_now_o);
          errors++;
        end
      end
    end
  end

endmodule
